[sv/assert_macros.svh]
// Assertion macros shared by the RTL; they compile to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check a property on every rising edge of clk outside reset.
`define DD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Check that a consequent holds in the cycle after its antecedent.
`define DD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DD_ASSERT(lbl, prop)
`define DD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[sv/dd_pkg.sv]
// Widths, calendar constants and calendar lookup functions for the date difference block.
package dd_pkg;

  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int DAYNUM_W = 23;
  localparam int DIFF_W   = 23;
  localparam int MONTHS   = 12;

  // Saturation limit on the magnitude of the day count.
  localparam logic signed [DIFF_W+1:0] SAT_LIMIT = 25'sd3652059;

  // Reciprocal for floor(y / 100): (y * DIV100_MUL) >> DIV100_SHIFT, exact for y < 2**14.
  localparam int DIV100_SHIFT = 21;
  localparam logic [14:0] DIV100_MUL = 15'd20972;

  localparam logic [MONTH_W-1:0] FEBRUARY     = 4'd2;
  localparam logic [DAY_W-1:0]   LEAP_FEB_LEN = 5'd29;

  localparam logic [DAY_W-1:0] MONTH_LEN [MONTHS] =
    '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};
  localparam logic [8:0] DAYS_BEFORE [MONTHS] =
    '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181, 9'd212, 9'd243, 9'd273,
      9'd304, 9'd334};

  // Day number of one date and whether the date is valid.
  typedef struct packed {
    logic [DAYNUM_W-1:0] num;
    logic                ok;
  } dd_daynum_t;

  // True when the month lies in 1..12.
  function automatic logic month_ok(input logic [MONTH_W-1:0] m);
    return (m >= 4'd1) && (m <= 4'd12);
  endfunction

  // Length of a month; zero for a month outside the calendar.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    len = '0;
    if (month_ok(m)) begin
      len = MONTH_LEN[m - 4'd1];
    end
    if (m == FEBRUARY && leap) begin
      len = LEAP_FEB_LEN;
    end
    return len;
  endfunction

  // Days in the whole months before month m of a common year.
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] n;
    n = '0;
    if (month_ok(m)) begin
      n = DAYS_BEFORE[m - 4'd1];
    end
    return n;
  endfunction

endpackage

[sv/dd_daynum.sv]
// Three-stage pipeline that turns one date into its day number counted from year 0.
module dd_daynum import dd_pkg::*; (
  input  logic               clk,
  input  logic [YEAR_W-1:0]  year_i,
  input  logic [MONTH_W-1:0] month_i,
  input  logic [DAY_W-1:0]   day_i,
  output dd_daynum_t         res_o
);

  // Stage A: century quotient by reciprocal multiplication.
  logic [YEAR_W+14:0]  prod;
  logic [7:0]          qa_r;
  logic [YEAR_W-1:0]   ya_r;
  logic [MONTH_W-1:0]  ma_r;
  logic [DAY_W-1:0]    da_r;

  assign prod = {15'd0, year_i} * {{YEAR_W{1'b0}}, DIV100_MUL};

  always_ff @(posedge clk) begin
    qa_r <= prod[DIV100_SHIFT+7:DIV100_SHIFT];
    ya_r <= year_i;
    ma_r <= month_i;
    da_r <= day_i;
  end

  // Stage B: leap rule, validity, whole-year days and the small correction terms.
  logic [YEAR_W-1:0]   q100;
  logic                div4, div100, div400, leap;
  logic [12:0]         ceil4;
  logic [7:0]          ceil100;
  logic [5:0]          ceil400;
  logic [DAY_W-1:0]    len;
  logic [13:0]         small_nxt;
  logic [DAYNUM_W-1:0] y365_nxt;
  logic                ok_nxt;
  logic [13:0]         small_r;
  logic [DAYNUM_W-1:0] y365_r;
  logic                okb_r;

  always_comb begin
    q100    = {qa_r, 6'd0} + {1'b0, qa_r, 5'd0} + {4'd0, qa_r, 2'd0};
    div4    = (ya_r[1:0] == 2'd0);
    div100  = (q100 == ya_r);
    div400  = div100 && (qa_r[1:0] == 2'd0);
    leap    = (div4 && !div100) || div400;
    ceil4   = {1'b0, ya_r[YEAR_W-1:2]} + {12'd0, !div4};
    ceil100 = qa_r + {7'd0, !div100};
    ceil400 = qa_r[7:2] + {5'd0, !div400};
    len     = month_len(ma_r, leap);
    ok_nxt  = month_ok(ma_r) && (da_r != '0) && (da_r <= len);
    small_nxt = {1'b0, ceil4} - {6'd0, ceil100} + {8'd0, ceil400}
              + {5'd0, days_before(ma_r)}
              + {13'd0, (leap && ma_r > FEBRUARY)} + {9'd0, da_r};
    y365_nxt = {1'b0, ya_r, 8'd0} + {3'b0, ya_r, 6'd0} + {4'b0, ya_r, 5'd0}
             + {6'b0, ya_r, 3'd0} + {7'b0, ya_r, 2'd0} + {9'b0, ya_r};
  end

  always_ff @(posedge clk) begin
    small_r <= small_nxt;
    y365_r  <= y365_nxt;
    okb_r   <= ok_nxt;
  end

  // Stage C: final day number.
  always_ff @(posedge clk) begin
    res_o.num <= y365_r + {{(DAYNUM_W-14){1'b0}}, small_r};
    res_o.ok  <= okb_r;
  end

endmodule

[sv/date_difference_in_days_top.sv]
// A date pair accepted at a clock edge passes through the input registers, the day-number
// stages A, B and C, the difference stage and the output register before out_valid shows it.
// Throughput: one transfer per cycle; busy stays low, so a new date pair may
// follow in every cycle through the six register stages of the pipeline.
// The receiver cannot stall; out_valid marks each result for one cycle.
// Reset (synchronous, rst_n low) clears the valid bits; data registers keep no reset.
`include "assert_macros.svh"
module date_difference_in_days_top import dd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [YEAR_W-1:0]        in_first_year,
  input  logic [MONTH_W-1:0]       in_first_month,
  input  logic [DAY_W-1:0]         in_first_day,
  input  logic [YEAR_W-1:0]        in_second_year,
  input  logic [MONTH_W-1:0]       in_second_month,
  input  logic [DAY_W-1:0]         in_second_day,
  input  logic                     in_include_end_day,
  output logic                     out_valid,
  output logic signed [DIFF_W-1:0] out_days_difference,
  output logic                     out_date_invalid
);

  localparam int DEPTH = 6;
  localparam logic signed [DIFF_W-1:0] DAYS_MAX = SAT_LIMIT[DIFF_W-1:0];

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Valid travels with the data through every stage; the include flag as far as the end-day adjustment.
  logic [DEPTH-1:0] vld_r;
  logic [DEPTH-1:0] vld_nxt;
  logic [DEPTH-2:0] inc_r;

  assign vld_nxt = {vld_r[DEPTH-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    inc_r <= {inc_r[DEPTH-3:0], in_include_end_day};
  end

  // Input registers.
  logic [YEAR_W-1:0]  y1_r, y2_r;
  logic [MONTH_W-1:0] m1_r, m2_r;
  logic [DAY_W-1:0]   d1_r, d2_r;

  always_ff @(posedge clk) begin
    y1_r <= in_first_year;
    m1_r <= in_first_month;
    d1_r <= in_first_day;
    y2_r <= in_second_year;
    m2_r <= in_second_month;
    d2_r <= in_second_day;
  end

  // Day numbers of both dates.
  dd_daynum_t first_dn, second_dn;

  dd_daynum u_first (
    .clk     (clk),
    .year_i  (y1_r),
    .month_i (m1_r),
    .day_i   (d1_r),
    .res_o   (first_dn)
  );

  dd_daynum u_second (
    .clk     (clk),
    .year_i  (y2_r),
    .month_i (m2_r),
    .day_i   (d2_r),
    .res_o   (second_dn)
  );

  // Difference stage.
  logic signed [DAYNUM_W:0] diff_r;
  logic                     ok_r;

  always_ff @(posedge clk) begin
    diff_r <= $signed({1'b0, second_dn.num}) - $signed({1'b0, first_dn.num});
    ok_r   <= first_dn.ok && second_dn.ok;
  end

  // End-day adjustment, saturation and output register.
  logic signed [DIFF_W+1:0] adj;
  logic signed [DIFF_W+1:0] sat;
  logic signed [DIFF_W-1:0] days_nxt;
  logic signed [DIFF_W-1:0] days_r;
  logic                     inv_r;

  always_comb begin
    adj = $signed({diff_r[DAYNUM_W], diff_r});
    if (inc_r[DEPTH-2]) begin
      if (diff_r < 0) begin
        adj = {diff_r[DAYNUM_W], diff_r} - 25'sd1;
      end else begin
        adj = {diff_r[DAYNUM_W], diff_r} + 25'sd1;
      end
    end
    sat = adj;
    if (adj > SAT_LIMIT) begin
      sat = SAT_LIMIT;
    end else if (adj < -SAT_LIMIT) begin
      sat = -SAT_LIMIT;
    end
    days_nxt = ok_r ? sat[DIFF_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    days_r <= days_nxt;
    inv_r  <= !ok_r;
  end

  assign out_valid           = vld_r[DEPTH-1];
  assign out_days_difference = days_r;
  assign out_date_invalid    = inv_r;

  // Checks on the result stream.
  `DD_ASSERT(a_invalid_zero, (out_valid && out_date_invalid) |-> (out_days_difference == '0))
  `DD_ASSERT(a_saturated, out_valid |-> (days_r <= DAYS_MAX && days_r >= -DAYS_MAX))
  `DD_ASSERT(a_latency, accept |-> ##6 out_valid)
  `DD_ASSERT_NEXT(a_no_ghost, !vld_r[DEPTH-2], !out_valid)

endmodule
